FILE: hdl/pal_pkg.sv
// Shared types and constants for the positional array list core.
// Holds action and status codes, controller states and the command/flag structs.
// No dependencies.
`default_nettype none

package pal_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 16;

  // Fixed field widths of the request and result items
  localparam int ACTION_W = 2;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_RM_RD,
    S_RM_CAP,
    S_RM_CHK,
    S_RM_RD2,
    S_RM_WR,
    S_RD_RD,
    S_RD_CAP,
    S_DONE
  } state_e;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX,
    RD_IDX_M1
  } rd_sel_e;

  // Memory write address/data select
  typedef enum logic [1:0] {
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load_req;
    logic                idx_from_cnt;
    logic                idx_from_pos;
    logic                idx_inc;
    logic                idx_dec;
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                wr_en;
    wr_sel_e             wr_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_clear;
    logic                res_capture;
    logic                status_load;
    logic [STATUS_W-1:0] status_code;
  } pal_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                full;
    logic                empty;
    logic                pos_gt_cnt;
    logic                pos_ge_cnt;
    logic                idx_eq_pos;
    logic                idx_eq_cnt;
  } pal_flags_t;

endpackage

`default_nettype wire

FILE: hdl/positional_array_list_core.sv
// Top level of the positional array list core.
// Joins the controller (pal_ctrl) and the datapath (pal_dpath); uses pal_pkg.
//
// A request is taken when start_i is high while busy_o is low. Its single
// result appears on status_o, result_value_o and entry_count_o for exactly
// one cycle with done_o high; the receiver cannot stall it, so it must take
// the result in that cycle. Entries sit in a single-port-write, single-port-
// read memory, and inserts and removes move one entry per read/write pair.
// busy_o stays high from the accepting edge until the result is shown with
// done_o; a refused request goes from decode straight to done, while inserts
// and removes run longer the more entries lie after the position. The next
// request can be taken in the cycle after done_o.
// The entry memory needs no clearing after reset.
`default_nettype none

module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic        [pal_pkg::ACTION_W-1:0] action_i,
  input  wire logic        [pal_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [pal_pkg::VALUE_W-1:0]  value_i,
  output logic                                     done_o,
  output logic             [pal_pkg::STATUS_W-1:0] status_o,
  output logic signed      [pal_pkg::VALUE_W-1:0]  result_value_o,
  output logic             [pal_pkg::COUNT_W-1:0]  entry_count_o
);

  pal_pkg::pal_cmd_t   cmd;
  pal_pkg::pal_flags_t flags;

  // Sequencer
  pal_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Storage and arithmetic
  pal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .flags_o        (flags),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

FILE: hdl/pal_ctrl.sv
// Controller state machine of the positional array list core.
// Decodes the registered request and steps the datapath through shift loops.
// Depends on pal_pkg.
`default_nettype none

module pal_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire pal_pkg::pal_flags_t flags_i,
  output pal_pkg::pal_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  pal_pkg::state_e state_q, state_d;
  logic [pal_pkg::STATUS_W-1:0] dec_status;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pal_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request check against the current fill
  always_comb begin
    dec_status = pal_pkg::ST_OK;
    priority if (flags_i.action == pal_pkg::ACT_INSERT) begin
      if (flags_i.full)            dec_status = pal_pkg::ST_FULL;
      else if (flags_i.pos_gt_cnt) dec_status = pal_pkg::ST_BADPOS;
    end else if (flags_i.action == pal_pkg::ACT_REMOVE) begin
      if (flags_i.empty)           dec_status = pal_pkg::ST_EMPTY;
      else if (flags_i.pos_ge_cnt) dec_status = pal_pkg::ST_BADPOS;
    end else if (flags_i.action == pal_pkg::ACT_READ) begin
      if (flags_i.pos_ge_cnt)      dec_status = pal_pkg::ST_BADPOS;
    end else begin
      dec_status = pal_pkg::ST_BADPOS;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        if (start_i) state_d = pal_pkg::S_DECODE;
      end
      pal_pkg::S_DECODE: begin
        if (dec_status != pal_pkg::ST_OK)               state_d = pal_pkg::S_DONE;
        else if (flags_i.action == pal_pkg::ACT_INSERT) state_d = pal_pkg::S_INS_CHK;
        else if (flags_i.action == pal_pkg::ACT_REMOVE) state_d = pal_pkg::S_RM_RD;
        else                                            state_d = pal_pkg::S_RD_RD;
      end
      pal_pkg::S_INS_CHK: begin
        state_d = flags_i.idx_eq_pos ? pal_pkg::S_INS_NEW : pal_pkg::S_INS_RD;
      end
      pal_pkg::S_INS_RD:  state_d = pal_pkg::S_INS_WR;
      pal_pkg::S_INS_WR:  state_d = pal_pkg::S_INS_CHK;
      pal_pkg::S_INS_NEW: state_d = pal_pkg::S_DONE;
      pal_pkg::S_RM_RD:   state_d = pal_pkg::S_RM_CAP;
      pal_pkg::S_RM_CAP:  state_d = pal_pkg::S_RM_CHK;
      pal_pkg::S_RM_CHK: begin
        state_d = flags_i.idx_eq_cnt ? pal_pkg::S_DONE : pal_pkg::S_RM_RD2;
      end
      pal_pkg::S_RM_RD2:  state_d = pal_pkg::S_RM_WR;
      pal_pkg::S_RM_WR:   state_d = pal_pkg::S_RM_CHK;
      pal_pkg::S_RD_RD:   state_d = pal_pkg::S_RD_CAP;
      pal_pkg::S_RD_CAP:  state_d = pal_pkg::S_DONE;
      pal_pkg::S_DONE:    state_d = pal_pkg::S_IDLE;
      default:            state_d = pal_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = pal_pkg::RD_POS;
    cmd_o.wr_sel = pal_pkg::WR_NEW;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        cmd_o.load_req = start_i;
      end
      pal_pkg::S_DECODE: begin
        cmd_o.status_load  = 1'b1;
        cmd_o.status_code  = dec_status;
        cmd_o.res_clear    = 1'b1;
        cmd_o.idx_from_cnt = 1'b1;
      end
      pal_pkg::S_INS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pal_pkg::RD_IDX_M1;
      end
      pal_pkg::S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = pal_pkg::WR_UP;
        cmd_o.idx_dec = 1'b1;
      end
      pal_pkg::S_INS_NEW: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = pal_pkg::WR_NEW;
        cmd_o.cnt_inc = 1'b1;
      end
      pal_pkg::S_RM_RD, pal_pkg::S_RD_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pal_pkg::RD_POS;
      end
      pal_pkg::S_RM_CAP: begin
        cmd_o.res_capture  = 1'b1;
        cmd_o.idx_from_pos = 1'b1;
      end
      pal_pkg::S_RM_CHK: begin
        cmd_o.cnt_dec = flags_i.idx_eq_cnt;
      end
      pal_pkg::S_RM_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pal_pkg::RD_IDX;
      end
      pal_pkg::S_RM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = pal_pkg::WR_DOWN;
        cmd_o.idx_inc = 1'b1;
      end
      pal_pkg::S_RD_CAP: begin
        cmd_o.res_capture = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != pal_pkg::S_IDLE);
  assign done_o = (state_q == pal_pkg::S_DONE);

endmodule

`default_nettype wire

FILE: hdl/pal_dpath.sv
// Datapath of the positional array list core: request registers, entry memory,
// fill count, shift index and result registers. Depends on pal_pkg.
`default_nettype none

module pal_dpath #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pal_pkg::pal_cmd_t                   cmd_i,
  input  wire logic        [pal_pkg::ACTION_W-1:0] action_i,
  input  wire logic        [pal_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [pal_pkg::VALUE_W-1:0]  value_i,
  output pal_pkg::pal_flags_t                      flags_o,
  output logic             [pal_pkg::STATUS_W-1:0] status_o,
  output logic signed      [pal_pkg::VALUE_W-1:0]  result_value_o,
  output logic             [pal_pkg::COUNT_W-1:0]  entry_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = pal_pkg::POS_W;
  localparam int WW = (CW > PW) ? CW : PW;
  localparam int VW = pal_pkg::VALUE_W;
  localparam int OW = pal_pkg::COUNT_W;

  // Registered request
  logic [pal_pkg::ACTION_W-1:0] action_q;
  logic [PW-1:0]                pos_q;
  logic [VW-1:0]                value_q;

  // Fill count and shift index
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;

  // Entry memory
  logic [VW-1:0] mem [CAPACITY];
  logic [VW-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic [VW-1:0] wdata;

  // Result registers
  logic [pal_pkg::STATUS_W-1:0] status_q;
  logic [VW-1:0]                res_q;

  logic [WW-1:0] pos_w, cnt_w, idx_w;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      action_q <= action_i;
      pos_q    <= position_i;
      value_q  <= value_i;
    end
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc)      count_d = count_q + CW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Shift index: walks down from count on insert, up from pos+1 on remove
  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_from_cnt) idx_d = count_q;
    else if (cmd_i.idx_from_pos)     idx_d = CW'(pos_q) + CW'(1);
    else if (cmd_i.idx_inc)          idx_d = idx_q + CW'(1);
    else if (cmd_i.idx_dec)          idx_d = idx_q - CW'(1);
    else                             idx_d = idx_q;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Address and data selection
  always_comb begin
    unique case (cmd_i.rd_sel)
      pal_pkg::RD_IDX:    raddr = AW'(idx_q);
      pal_pkg::RD_IDX_M1: raddr = AW'(idx_q - CW'(1));
      default:            raddr = AW'(pos_q);
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      pal_pkg::WR_UP: begin
        waddr = AW'(idx_q);
        wdata = rdata_q;
      end
      pal_pkg::WR_DOWN: begin
        waddr = AW'(idx_q - CW'(1));
        wdata = rdata_q;
      end
      default: begin
        waddr = AW'(pos_q);
        wdata = value_q;
      end
    endcase
  end

  // Single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.status_load) status_q <= cmd_i.status_code;
    if (cmd_i.res_clear)        res_q <= '0;
    else if (cmd_i.res_capture) res_q <= rdata_q;
  end

  // Flags for the controller
  assign pos_w = WW'(pos_q);
  assign cnt_w = WW'(count_q);
  assign idx_w = WW'(idx_q);

  always_comb begin
    flags_o.action     = action_q;
    flags_o.full       = (count_q == CW'(CAPACITY));
    flags_o.empty      = (count_q == '0);
    flags_o.pos_gt_cnt = (pos_w > cnt_w);
    flags_o.pos_ge_cnt = (pos_w >= cnt_w);
    flags_o.idx_eq_pos = (idx_w == pos_w);
    flags_o.idx_eq_cnt = (idx_q == count_q);
  end

  assign status_o       = status_q;
  assign result_value_o = res_q;
  assign entry_count_o  = OW'(count_q);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for positional_array_list_core.
// Holds its own model of the ordered list, a queue-fed item driver and a result monitor.
// Depends on pal_pkg and the core's RTL.

module tb;
  import pal_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int TAIL_CYCLES  = 60;       // longer than the slowest request
  localparam int LIMIT_TIME   = 3000000;  // whole-run time limit
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    bit                        hold_for_drain;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [ACTION_W-1:0]        action_i = '0;
  logic [POS_W-1:0]           position_i = '0;
  logic signed [VALUE_W-1:0]  value_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [VALUE_W-1:0]  result_value_o;
  logic [COUNT_W-1:0]         entry_count_o;

  positional_array_list_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

  // Items waiting to be sent, results waiting to arrive
  list_req_t    pending_items[$];
  list_result_t expected_results[$];
  int           outstanding = 0;   // registered copy of expected_results.size()

  // Shadow list state
  logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
  int                        shadow_count = 0;

  // Stimulus-side count, tracks only how many entries the list holds
  int plan_count = 0;

  int mismatches = 0;
  int accepted = 0;
  int status_hits [4] = '{default: 0};
  int peak_count = 0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Expected outcome of one request; updates the shadow list
  function automatic list_result_t apply_request(input logic [ACTION_W-1:0] act,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int p;
    r.status = ST_OK;
    r.value  = '0;
    p = int'(pos);
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (p > shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = shadow_list[p];
          for (int i = p + 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
          shadow_count--;
        end
      end
      ACT_READ: begin
        if (p >= shadow_count) r.status = ST_BADPOS;
        else r.value = shadow_list[p];
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Queue one item and keep the planned count in step
  function automatic void add_item(input logic [ACTION_W-1:0] act, input int pos,
                                   input logic signed [VALUE_W-1:0] val,
                                   input bit hold = 1'b0);
    list_req_t it;
    it.action = act;
    it.position = pos[POS_W-1:0];
    it.value = val;
    it.hold_for_drain = hold;
    pending_items.push_back(it);
    if (act == ACT_INSERT && plan_count < LIST_DEPTH && pos <= plan_count) plan_count++;
    else if (act == ACT_REMOVE && plan_count > 0 && pos < plan_count) plan_count--;
  endfunction

  // Mix of extremes and random words
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int mode;
    int phase_left;
    int roll;
    int pos;
    int n;
    logic [ACTION_W-1:0] act;

    // Directed: empty-list cases, fill to full, full-list and boundary cases
    add_item(ACT_READ, 0, 32'sd7);
    add_item(ACT_REMOVE, 0, '0);
    add_item(ACT_REMOVE, 15, '0);
    add_item(ACT_INSERT, 1, 32'sd5);
    add_item(ACT_UNUSED, 0, VAL_MAX);
    for (int k = 0; k < LIST_DEPTH; k++) begin
      pos = (k % 3 == 0) ? 0 : (k % 3 == 1) ? plan_count : plan_count / 2;
      add_item(ACT_INSERT, pos, (k == 0) ? VAL_MIN : (k == 1) ? VAL_MAX : pick_value());
    end
    add_item(ACT_INSERT, 3, 32'sd99);
    add_item(ACT_READ, 15, '0);
    add_item(ACT_REMOVE, 15, '0);
    add_item(ACT_REMOVE, 0, '0);
    add_item(ACT_READ, 14, '0);
    add_item(ACT_UNUSED, 15, VAL_MIN);

    // Random: phases biased toward filling, draining or mixing the list
    mode = 0;
    phase_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) act = ACT_UNUSED;
      else if (mode == 0) act = (roll < 70) ? ACT_INSERT : (roll < 85) ? ACT_REMOVE : ACT_READ;
      else if (mode == 1) act = (roll < 20) ? ACT_INSERT : (roll < 75) ? ACT_REMOVE : ACT_READ;
      else act = (roll < 40) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE : ACT_READ;

      // Mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 15);
      else if (act == ACT_INSERT) pos = (plan_count >= 15) ? 15 : $urandom_range(0, plan_count);
      else if (plan_count == 0) pos = $urandom_range(0, 15);
      else pos = $urandom_range(0, plan_count - 1);

      add_item(act, pos, pick_value(), (n % 400 == 0));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, every result in, then a quiet tail
    do @(negedge clk_i); while (pending_items.size() != 0 || start_i || outstanding != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("Sent %0d requests: %0d ok, %0d full, %0d empty, %0d bad position.",
             accepted, status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADPOS]);
    $display("List depth peaked at %0d entries; %0d mismatches.", peak_count, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(LIMIT_TIME);
    $display("Timeout: run did not finish");
    $display("CHECKS FAILED");
    $finish;
  end

  // Driver: bursts with random gaps, holds an item until it is taken
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    logic took;
    logic drive_next;
    if (!rst_ni) begin
      burst_left = $urandom_range(1, 10);
      gap_left = 0;
    end else begin
      took = start_i && !busy_o;
      drive_next = 1'b0;
      if (took) begin
        void'(pending_items.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 10);
        end
      end
      if (start_i && !took) begin
        drive_next = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() != 0 &&
                   (!pending_items[0].hold_for_drain || (!took && outstanding == 0))) begin
        // A held item waits until the list has no result in flight
        drive_next = 1'b1;
        action_i   <= pending_items[0].action;
        position_i <= pending_items[0].position;
        value_i    <= pending_items[0].value;
      end
      start_i <= drive_next;
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted items
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: status %0d value %0d count %0d",
                     status_o, result_value_o, entry_count_o);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || result_value_o !== want.value ||
              entry_count_o !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                       want.status, want.value, want.count,
                       status_o, result_value_o, entry_count_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        want = apply_request(action_i, position_i, value_i);
        expected_results.push_back(want);
        accepted++;
        status_hits[want.status]++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: filelist.f
hdl/pal_pkg.sv
hdl/pal_ctrl.sv
hdl/pal_dpath.sv
hdl/positional_array_list_core.sv
tb/tb.sv
